>>> design/search_and_delete_compacting_table_assert.svh
// Assertion macros used by the compacting table checker.
`ifndef SEARCH_AND_DELETE_COMPACTING_TABLE_ASSERT_SVH
`define SEARCH_AND_DELETE_COMPACTING_TABLE_ASSERT_SVH

// Same-cycle implication, sampled on clk and quiet while rst_n is low.
`define SDCT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk and quiet while rst_n is low.
`define SDCT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> design/sdct_pkg.sv
// Package with the request, result and cell control types of the compacting table.
`timescale 1ns / 1ps
package sdct_pkg;

  localparam int DATA_W    = 32;
  localparam int OP_W      = 2;
  localparam int INDEX_W   = 4;
  localparam int POS_W     = 4;
  localparam int LEN_W     = 5;
  localparam int STATUS_W  = 2;
  localparam int DEPTH_DEF = 16;

  typedef enum logic [OP_W-1:0] {
    OP_APPEND = 2'd0,
    OP_REMOVE = 2'd1,
    OP_READ   = 2'd2,
    OP_NONE   = 2'd3
  } sdct_op_t;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK    = 2'd0,
    STS_MISS  = 2'd1,
    STS_FULL  = 2'd2,
    STS_RANGE = 2'd3
  } sdct_status_t;

  typedef struct packed {
    sdct_op_t                   op;
    logic signed [DATA_W-1:0]   value;
    logic        [INDEX_W-1:0]  index;
  } sdct_req_t;

  typedef struct packed {
    sdct_status_t               status;
    logic        [POS_W-1:0]    position;
    logic        [LEN_W-1:0]    length;
    logic signed [DATA_W-1:0]   read_value;
  } sdct_rsp_t;

  typedef struct packed {
    logic shift;
    logic load;
  } sdct_cell_ctrl_t;

endpackage

>>> design/sdct_cell.sv
// Cell: holds and compares an entry; loads one or, on a shift, takes the right neighbor's.
`timescale 1ns / 1ps
module sdct_cell (
  input  logic                              clk,
  input  logic                              cmp_en,
  input  logic signed [sdct_pkg::DATA_W-1:0] cmp_value,
  input  sdct_pkg::sdct_cell_ctrl_t         ctrl,
  input  logic signed [sdct_pkg::DATA_W-1:0] load_value,
  input  logic signed [sdct_pkg::DATA_W-1:0] next_value,
  output logic signed [sdct_pkg::DATA_W-1:0] entry,
  output logic                              eq
);
  import sdct_pkg::*;

  logic signed [DATA_W-1:0] entry_r;
  logic                     eq_r;

  always_ff @(posedge clk) begin
    if (cmp_en) begin
      eq_r <= (entry_r == cmp_value);
    end
    if (ctrl.shift) begin
      entry_r <= next_value;
    end else if (ctrl.load) begin
      entry_r <= load_value;
    end
  end

  assign entry = entry_r;
  assign eq    = eq_r;

endmodule

>>> design/sdct_first_hit.sv
// First-match finder: marks the first hit and every place above it, and encodes its position.
`timescale 1ns / 1ps
module sdct_first_hit #(
  parameter int DEPTH = sdct_pkg::DEPTH_DEF,
  parameter int IDX_W = $clog2(DEPTH)
) (
  input  logic [DEPTH-1:0] hit,
  output logic             found,
  output logic [DEPTH-1:0] at_or_above,
  output logic [IDX_W-1:0] pos
);
  import sdct_pkg::*;

  logic [DEPTH-1:0] first;

  for (genvar gi = 0; gi < DEPTH; gi++) begin : g_scan
    assign at_or_above[gi] = |hit[gi:0];
    if (gi == 0) begin : g_low
      assign first[gi] = hit[gi];
    end else begin : g_up
      assign first[gi] = hit[gi] & ~at_or_above[gi-1];
    end
  end

  always_comb begin
    pos = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (first[i]) begin
        pos = pos | IDX_W'(i);
      end
    end
  end

  assign found = |hit;

endmodule

>>> design/search_and_delete_compacting_table.sv
// Top level of the compacting table: control, length count, row of cells and result register.
//
//   Channel  Ports                          Direction  Payload
//   in       in_valid, in_ready, in_data    request    sdct_req_t (op, value, index)
//   out      out_valid, out_ready, out_data result     sdct_rsp_t (status, position,
//                                                       length, read_value)
//
// In the accept cycle of a request each cell registers its compare against the request
// value; in the apply state, once the result register is free, the first-match finder
// steers the shift of a remove and the result register is loaded.
// A new request is taken while a finished result still waits in the result register;
// the apply state holds until that register is free.
// Reset clears the length and the control state; entry contents are not cleared.
`timescale 1ns / 1ps
module search_and_delete_compacting_table #(
  parameter int DEPTH = sdct_pkg::DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  sdct_pkg::sdct_req_t in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output sdct_pkg::sdct_rsp_t out_data
);
  import sdct_pkg::*;

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_APPLY = 2'b10
  } sdct_state_t;

  sdct_state_t     state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  sdct_req_t       req_r, req_nxt;
  sdct_rsp_t       out_r, out_nxt;
  logic            out_valid_r, out_valid_nxt;

  logic                     in_acc;
  logic                     do_apply;
  logic [DEPTH-1:0]         cell_eq;
  logic [DEPTH-1:0]         hit;
  logic                     found;
  logic [DEPTH-1:0]         at_or_above;
  logic [IDX_W-1:0]         hit_pos;
  logic signed [DATA_W-1:0] cell_entry [DEPTH];
  sdct_cell_ctrl_t          cell_ctrl  [DEPTH];

  assign in_ready = (state_r == ST_IDLE);
  assign in_acc   = in_valid & in_ready;
  assign do_apply = (state_r == ST_APPLY) & (~out_valid_r | out_ready);

  for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
    logic signed [DATA_W-1:0] right_value;
    if (gi == DEPTH - 1) begin : g_last
      assign right_value = cell_entry[gi];
    end else begin : g_mid
      assign right_value = cell_entry[gi+1];
    end

    sdct_cell u_cell (
      .clk        (clk),
      .cmp_en     (in_acc),
      .cmp_value  (in_data.value),
      .ctrl       (cell_ctrl[gi]),
      .load_value (req_r.value),
      .next_value (right_value),
      .entry      (cell_entry[gi]),
      .eq         (cell_eq[gi])
    );

    assign hit[gi] = cell_eq[gi] & (CNT_W'(gi) < count_r);
  end

  sdct_first_hit #(
    .DEPTH (DEPTH),
    .IDX_W (IDX_W)
  ) u_first_hit (
    .hit         (hit),
    .found       (found),
    .at_or_above (at_or_above),
    .pos         (hit_pos)
  );

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    req_nxt       = req_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    for (int i = 0; i < DEPTH; i++) begin
      cell_ctrl[i] = '0;
    end

    if (in_acc) begin
      req_nxt   = in_data;
      state_nxt = ST_APPLY;
    end

    if (do_apply) begin
      out_nxt       = '0;
      out_nxt.status = STS_OK;
      out_valid_nxt = 1'b1;
      state_nxt     = ST_IDLE;
      case (req_r.op)
        OP_APPEND: begin
          if (count_r >= CNT_W'(DEPTH)) begin
            out_nxt.status = STS_FULL;
          end else begin
            for (int i = 0; i < DEPTH; i++) begin
              cell_ctrl[i].load = (CNT_W'(i) == count_r);
            end
            count_nxt = count_r + CNT_W'(1);
          end
        end
        OP_REMOVE: begin
          if (!found) begin
            out_nxt.status = STS_MISS;
          end else begin
            for (int i = 0; i < DEPTH; i++) begin
              cell_ctrl[i].shift = at_or_above[i] & (CNT_W'(i + 1) < count_r);
            end
            count_nxt        = count_r - CNT_W'(1);
            out_nxt.position = POS_W'(hit_pos);
          end
        end
        OP_READ: begin
          if (32'(req_r.index) >= 32'(count_r)) begin
            out_nxt.status = STS_RANGE;
          end else begin
            out_nxt.read_value = cell_entry[IDX_W'(req_r.index)];
          end
        end
        default: begin
          out_nxt.status = STS_OK;
        end
      endcase
      out_nxt.length = LEN_W'(count_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r <= req_nxt;
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

>>> design/sdct_checker.sv
// Port-level checker for the compacting table and its bind to the top level.
`timescale 1ns / 1ps
`include "search_and_delete_compacting_table_assert.svh"
module sdct_checker #(
  parameter int DEPTH = sdct_pkg::DEPTH_DEF
) (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input sdct_pkg::sdct_req_t in_data,
  input logic                out_valid,
  input logic                out_ready,
  input sdct_pkg::sdct_rsp_t out_data
);
  import sdct_pkg::*;

  logic in_seen;
  assign in_seen = in_valid & in_ready & (in_data.op == OP_NONE);

  `SDCT_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "stalled result changed")
  `SDCT_ASSERT_IMP(a_full_len, out_valid && out_data.status == STS_FULL, out_data.length == LEN_W'(DEPTH), "table full reported below depth")
  `SDCT_ASSERT_IMP(a_miss_zero, out_valid && out_data.status == STS_MISS, out_data.position == '0 && out_data.read_value == '0, "missed remove carries data")
  `SDCT_ASSERT_IMP(a_len_max, out_valid || in_seen, 32'(out_data.length) <= DEPTH || !out_valid, "length above depth")

endmodule

bind search_and_delete_compacting_table sdct_checker #(
  .DEPTH (DEPTH)
) u_sdct_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

>>> test/search_and_delete_compacting_table_tb.sv
// Compacting table testbench: directed and random requests, checked by a predictor or typed results.
`timescale 1ns / 1ps
module search_and_delete_compacting_table_tb;
  import sdct_pkg::*;

  localparam int DEPTH      = DEPTH_DEF;
  localparam int RANDOM_N   = 1125;
  localparam int HOLD_N     = 40;
  localparam int STALL_MAX  = 1000;
  localparam int DRAIN_N    = 8;

  typedef struct packed {
    sdct_req_t req;
    logic      typed;
    sdct_rsp_t rsp;
  } plan_row_t;

  localparam plan_row_t DIRECTED_PLAN[26] = '{
    '{'{OP_READ,   32'sh0000_0000, 4'd0},  1'b1, '{STS_RANGE, 4'd0, 5'd0,  32'sd0}},
    '{'{OP_REMOVE, 32'sh0000_0000, 4'd0},  1'b1, '{STS_MISS,  4'd0, 5'd0,  32'sd0}},
    '{'{OP_NONE,   32'shFFFF_FFFF, 4'd15}, 1'b1, '{STS_OK,    4'd0, 5'd0,  32'sd0}},
    '{'{OP_APPEND, 32'sh8000_0000, 4'd0},  1'b0, '0},
    '{'{OP_APPEND, 32'sh7FFF_FFFF, 4'd0},  1'b0, '0},
    '{'{OP_APPEND, 32'shFFFF_FFFF, 4'd0},  1'b0, '0},
    '{'{OP_APPEND, 32'sh0000_0000, 4'd0},  1'b0, '0},
    '{'{OP_APPEND, 32'sh5555_5555, 4'd0},  1'b0, '0},
    '{'{OP_APPEND, 32'shAAAA_AAAA, 4'd0},  1'b0, '0},
    '{'{OP_APPEND, 32'sh0000_0001, 4'd0},  1'b0, '0},
    '{'{OP_APPEND, 32'sh0000_0010, 4'd0},  1'b0, '0},
    '{'{OP_APPEND, 32'sh1234_5678, 4'd0},  1'b0, '0},
    '{'{OP_APPEND, 32'sh7FFF_FFFE, 4'd0},  1'b0, '0},
    '{'{OP_APPEND, 32'shFFFF_FFFF, 4'd0},  1'b0, '0},
    '{'{OP_APPEND, 32'sh8000_0001, 4'd0},  1'b0, '0},
    '{'{OP_APPEND, 32'sh0F0F_0F0F, 4'd0},  1'b0, '0},
    '{'{OP_APPEND, 32'shF0F0_F0F0, 4'd0},  1'b0, '0},
    '{'{OP_APPEND, 32'sh0000_0002, 4'd0},  1'b0, '0},
    '{'{OP_APPEND, 32'sh3C3C_C3C3, 4'd0},  1'b0, '0},
    '{'{OP_APPEND, 32'sh0000_0003, 4'd0},  1'b1, '{STS_FULL,  4'd0, 5'd16, 32'sd0}},
    '{'{OP_READ,   32'sh0000_0000, 4'd15}, 1'b0, '0},
    '{'{OP_REMOVE, 32'shFFFF_FFFF, 4'd0},  1'b0, '0},
    '{'{OP_READ,   32'sh0000_0000, 4'd15}, 1'b1, '{STS_RANGE, 4'd0, 5'd15, 32'sd0}},
    '{'{OP_REMOVE, 32'sh8000_0000, 4'd0},  1'b0, '0},
    '{'{OP_REMOVE, 32'sh3C3C_C3C3, 4'd0},  1'b0, '0},
    '{'{OP_NONE,   32'sh0000_0000, 4'd0},  1'b1, '{STS_OK,    4'd0, 5'd13, 32'sd0}}
  };

  logic      clk;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  sdct_req_t in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  sdct_rsp_t out_data;

  logic signed [DATA_W-1:0] shadow_entries[DEPTH];
  int        shadow_len = 0;
  sdct_rsp_t pending_results[$];
  sdct_rsp_t head_rsp;
  int        mismatches = 0;
  int        quiet_cycles = 0;
  bit        calm = 1'b0;
  bit        squeeze = 1'b0;
  bit        filling = 1'b1;

  search_and_delete_compacting_table dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic sdct_rsp_t table_step(input sdct_req_t req);
    sdct_rsp_t rsp;
    int        hit;
    rsp = '0;
    hit = -1;
    case (req.op)
      OP_APPEND: begin
        if (shadow_len >= DEPTH) begin
          rsp.status = STS_FULL;
        end else begin
          shadow_entries[shadow_len] = req.value;
          shadow_len++;
        end
      end
      OP_REMOVE: begin
        for (int i = 0; i < shadow_len; i++) begin
          if (hit < 0 && shadow_entries[i] == req.value) hit = i;
        end
        if (hit < 0) begin
          rsp.status = STS_MISS;
        end else begin
          for (int i = hit; i + 1 < shadow_len; i++) shadow_entries[i] = shadow_entries[i + 1];
          shadow_len--;
          rsp.position = hit[POS_W-1:0];
        end
      end
      OP_READ: begin
        if (int'(req.index) >= shadow_len) rsp.status = STS_RANGE;
        else rsp.read_value = shadow_entries[req.index];
      end
      default: begin
      end
    endcase
    rsp.length = shadow_len[LEN_W-1:0];
    return rsp;
  endfunction

  // Well-formed traffic: removes mostly target stored values, and the mix swings between
  // filling and draining so that both the full and the empty table are reached often.
  function automatic sdct_req_t random_request();
    sdct_req_t req;
    int        roll;
    int        pick;
    if (shadow_len == DEPTH && $urandom_range(3) == 0) filling = 1'b0;
    if (shadow_len == 0 && $urandom_range(3) == 0) filling = 1'b1;
    roll = $urandom_range(99);
    if (roll < 5) req.op = OP_NONE;
    else if (roll < 35) req.op = OP_READ;
    else if ((roll < 80) == filling) req.op = OP_APPEND;
    else req.op = OP_REMOVE;
    if (shadow_len > 0 && $urandom_range(1) == 1) req.index = 4'($urandom_range(shadow_len - 1));
    else req.index = 4'($urandom_range(15));
    pick = $urandom_range(9);
    if (req.op == OP_REMOVE && shadow_len > 0 && pick < 7) begin
      req.value = shadow_entries[$urandom_range(shadow_len - 1)];
    end else if (pick < 4) begin
      req.value = $urandom_range(7);
      req.value = req.value - 4;
    end else if (pick == 4) begin
      req.value = $urandom_range(1) ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      req.value = $urandom;
    end
    return req;
  endfunction

  task automatic offer_request(input sdct_req_t req, input bit typed, input sdct_rsp_t typed_rsp);
    sdct_rsp_t predicted;
    if (!calm && !squeeze && $urandom_range(99) < 31) begin
      in_valid <= 1'b0;
      do @(posedge clk); while (!calm && !squeeze && $urandom_range(99) < 31);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (!in_ready);
    predicted = table_step(req);
    pending_results.push_back(typed ? typed_rsp : predicted);
  endtask

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    if (squeeze) begin
      out_ready <= 1'b0;
      repeat (HOLD_N) @(posedge clk);
      squeeze = 1'b0;
    end
    out_ready <= calm || ($urandom_range(99) >= 31);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t ns: result with none expected, got %0h", $time, out_data);
        mismatches++;
      end else begin
        head_rsp = pending_results.pop_front();
        check_field("status", 32'(head_rsp.status), 32'(out_data.status));
        check_field("position", 32'(head_rsp.position), 32'(out_data.position));
        check_field("length", 32'(head_rsp.length), 32'(out_data.length));
        check_field("read_value", head_rsp.read_value, out_data.read_value);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_MAX) begin
      $display("%0t ns: no progress for %0d cycles", $time, STALL_MAX);
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (DIRECTED_PLAN[k]) begin
      offer_request(DIRECTED_PLAN[k].req, DIRECTED_PLAN[k].typed, DIRECTED_PLAN[k].rsp);
    end
    for (int n = 0; n < RANDOM_N; n++) begin
      calm = (n >= 300 && n < 500);
      if (n == 700) squeeze = 1'b1;
      offer_request(random_request(), 1'b0, '0);
    end
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_N) @(posedge clk);
    if (pending_results.size() != 0) begin
      $display("%0t ns: %0d results never arrived", $time, pending_results.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> search_and_delete_compacting_table.f
+incdir+design
design/sdct_pkg.sv
design/sdct_cell.sv
design/sdct_first_hit.sv
design/search_and_delete_compacting_table.sv
design/sdct_checker.sv
test/search_and_delete_compacting_table_tb.sv
